// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hdl/pss_pkg.sv =====
`timescale 1ns / 1ps

package pss_pkg;

    localparam int CHANNELS    = 16;
    localparam int CNT_W       = 5;
    localparam int CH_W        = 4;
    localparam int STORE_DEPTH = 16;
    localparam int SMP_W       = 15;
    localparam int OFF_W       = 12;
    localparam int PROB_W      = 17;
    localparam int DRAW_W      = 16;
    localparam int SPAN_W      = 11;
    localparam int SPAN_N      = 10;

    localparam logic signed [SMP_W-1:0] OUT_LIMIT     = 15'sd14000;
    localparam logic signed [SMP_W-1:0] RESET_HIGH_MV = 15'sd1000;

    localparam logic [1:0] MODE_FWD  = 2'd0;
    localparam logic [1:0] MODE_BWD  = 2'd1;
    localparam logic [1:0] MODE_RAND = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_STEP_PROB = 2'd1;
    localparam logic [1:0] CFG_OFF_PROB  = 2'd2;
    localparam logic [1:0] CFG_RANGE     = 2'd3;

    localparam logic [SPAN_W-1:0] SPAN_MV [SPAN_N] = '{
        11'd200, 11'd300, 11'd500, 11'd800, 11'd1000,
        11'd1200, 11'd1300, 11'd1500, 11'd1800, 11'd2000
    };

    typedef struct packed {
        logic [1:0]        mode;
        logic [PROB_W-1:0] step_prob;
        logic [PROB_W-1:0] off_prob;
        logic [3:0]        range_idx;
    } cfg_t;

    typedef struct packed {
        logic                    zero;
        logic                    both;
        logic signed [OFF_W-1:0] offset;
        logic [CH_W-1:0]         chan;
        logic                    skip;
    } step_res_t;

endpackage

// ===== hdl/pss_ram.sv =====
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pss_step.sv =====
`timescale 1ns / 1ps

module pss_step (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick,
    input  pss_pkg::cfg_t                    cfg,
    input  logic                             trigger_high,
    input  logic signed [pss_pkg::SMP_W-1:0] reset_mv,
    input  logic                             button_level,
    input  logic [pss_pkg::CNT_W-1:0]        channel_count,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_gate,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_offset_gate,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_magnitude,
    input  logic                             rand_sign,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_pick,
    output pss_pkg::step_res_t               res
);

    import pss_pkg::*;

    logic [CH_W-1:0]         step_reg, step_next;
    logic [DRAW_W-1:0]       gate_reg, gate_next;
    logic [DRAW_W-1:0]       ogate_reg, ogate_next;
    logic signed [OFF_W-1:0] offset_reg, offset_next;
    logic                    lvl_trig_reg, lvl_btn_reg, lvl_rst_reg;
    logic                    lvl_rst_next;
    logic                    skip_reg, skip_next;

    logic [CNT_W-1:0]           cnt;
    logic [CH_W-1:0]            last;
    logic                       rise_t, rise_b, rise_r, evt, pass;
    logic                       rst_hi, rst_lo;
    logic [3:0]                 span_idx;
    logic [DRAW_W+SPAN_W-1:0]   mag_prod;
    logic [SPAN_W-1:0]          mag;
    logic [DRAW_W+CNT_W-1:0]    pick_prod;
    logic [CNT_W-1:0]           inc;
    logic [CH_W-1:0]            fwd, bwd;

    always_comb
    begin
        cnt  = (channel_count > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : channel_count;
        last = (cnt == '0) ? '0 : CH_W'(cnt - CNT_W'(1));

        rst_hi = (reset_mv >= RESET_HIGH_MV);
        rst_lo = (reset_mv <= 15'sd0);
        rise_t = !lvl_trig_reg && trigger_high;
        rise_b = !lvl_btn_reg && button_level;
        rise_r = !lvl_rst_reg && rst_hi;
        lvl_rst_next = lvl_rst_reg ? !rst_lo : rst_hi;
        evt = rise_t || rise_b || rise_r;

        pass     = ({1'b0, rand_gate} <= cfg.step_prob);
        span_idx = (cfg.range_idx > 4'd9) ? 4'd9 : cfg.range_idx;
        mag_prod = rand_magnitude * SPAN_MV[span_idx];
        mag      = mag_prod[DRAW_W +: SPAN_W];
        pick_prod = rand_pick * cnt;

        inc = {1'b0, step_reg} + CNT_W'(1);
        fwd = (inc >= cnt || rise_r) ? '0 : inc[CH_W-1:0];
        if (rise_r || step_reg == '0)
        begin
            bwd = last;
        end
        else
        begin
            bwd = step_reg - CH_W'(1);
        end

        step_next   = step_reg;
        gate_next   = gate_reg;
        ogate_next  = ogate_reg;
        offset_next = offset_reg;
        skip_next   = skip_reg;

        if (evt)
        begin
            gate_next   = rand_gate;
            ogate_next  = rand_offset_gate;
            offset_next = rand_sign ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
            skip_next   = !pass;
            if (pass)
            begin
                case (cfg.mode)
                    MODE_FWD:  step_next = fwd;
                    MODE_BWD:  step_next = bwd;
                    MODE_RAND: step_next = pick_prod[DRAW_W +: CH_W];
                    default:   step_next = step_reg;
                endcase
            end
        end
        else if ({1'b0, step_reg} >= cnt)
        begin
            step_next = last;
        end

        res.zero   = (cnt == '0);
        res.both   = ({1'b0, ogate_next} <= cfg.off_prob)
                  && ({1'b0, gate_next} <= cfg.step_prob);
        res.offset = offset_next;
        res.chan   = step_next;
        res.skip   = skip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            gate_reg     <= '0;
            ogate_reg    <= '0;
            offset_reg   <= '0;
            lvl_trig_reg <= 1'b0;
            lvl_btn_reg  <= 1'b0;
            lvl_rst_reg  <= 1'b0;
            skip_reg     <= 1'b0;
        end
        else if (tick)
        begin
            step_reg     <= step_next;
            gate_reg     <= gate_next;
            ogate_reg    <= ogate_next;
            offset_reg   <= offset_next;
            lvl_trig_reg <= trigger_high;
            lvl_btn_reg  <= button_level;
            lvl_rst_reg  <= lvl_rst_next;
            skip_reg     <= skip_next;
        end
    end

endmodule

// ===== hdl/probabilistic_sequential_switch_top.sv =====
// A tick beat runs through step update and store read, then offset add, to a result beat.
// Throughput: one item per cycle while out_ready holds; a write beat gives no result.
// Rate set by the single-port read of the sample store and the output register.
// Reset (rst_n, async, low) clears step state and per-entry valid bits, sets
// config defaults; a never-written store entry reads as zero, so no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module probabilistic_sequential_switch_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [pss_pkg::PROB_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [pss_pkg::CH_W-1:0]         channel,
    input  logic signed [pss_pkg::SMP_W-1:0] sample_mv,
    input  logic                             trigger_high,
    input  logic signed [pss_pkg::SMP_W-1:0] reset_mv,
    input  logic                             button_level,
    input  logic [pss_pkg::CNT_W-1:0]        channel_count,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_gate,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_offset_gate,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_magnitude,
    input  logic                             rand_sign,
    input  logic [pss_pkg::DRAW_W-1:0]       rand_pick,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [pss_pkg::SMP_W-1:0] out_mv,
    output logic                             active_valid,
    output logic [pss_pkg::CH_W-1:0]         active_channel,
    output logic                             skipped,
    output logic                             offset_applied
);

    import pss_pkg::*;

    cfg_t      cfg_reg;
    step_res_t step_res;
    step_res_t s1_reg;
    logic      s1_valid_reg;

    logic [STORE_DEPTH-1:0] store_vld_reg;
    logic                   smp_vld_reg;
    logic [SMP_W-1:0]       ram_rdata;

    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] out_mv_reg, out_mv_next;
    logic                    active_valid_reg;
    logic [CH_W-1:0]         active_channel_reg;
    logic                    skipped_reg;
    logic                    offset_applied_reg;

    logic in_acc, tick_acc, wr_acc, out_free, s1_adv;
    logic signed [SMP_W-1:0] sample;
    logic signed [SMP_W:0]   sum;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_acc    = in_valid && in_ready;
    assign tick_acc  = in_acc && (op == OP_TICK);
    assign wr_acc    = in_acc && (op == OP_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_FWD;
            cfg_reg.step_prob <= PROB_W'(65536);
            cfg_reg.off_prob  <= '0;
            cfg_reg.range_idx <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:      cfg_reg.mode      <= cfg_data[1:0];
                CFG_STEP_PROB: cfg_reg.step_prob <= cfg_data;
                CFG_OFF_PROB:  cfg_reg.off_prob  <= cfg_data;
                CFG_RANGE:     cfg_reg.range_idx <= cfg_data[3:0];
            endcase
        end
    end

    pss_step u_step (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick             (tick_acc),
        .cfg              (cfg_reg),
        .trigger_high     (trigger_high),
        .reset_mv         (reset_mv),
        .button_level     (button_level),
        .channel_count    (channel_count),
        .rand_gate        (rand_gate),
        .rand_offset_gate (rand_offset_gate),
        .rand_magnitude   (rand_magnitude),
        .rand_sign        (rand_sign),
        .rand_pick        (rand_pick),
        .res              (step_res)
    );

    pss_ram #(
        .WIDTH (SMP_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_acc),
        .waddr (channel),
        .wdata (sample_mv),
        .re    (tick_acc),
        .raddr (step_res.chan),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_vld_reg <= '0;
            smp_vld_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_acc)
            begin
                store_vld_reg[channel] <= 1'b1;
            end
            if (tick_acc)
            begin
                smp_vld_reg  <= store_vld_reg[step_res.chan];
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_reg <= step_res;
        end
    end

    always_comb
    begin
        sample = smp_vld_reg ? $signed(ram_rdata) : '0;
        sum    = {sample[SMP_W-1], sample}
               + (s1_reg.both ? (SMP_W+1)'(s1_reg.offset) : '0);
        if (sum > (SMP_W+1)'(OUT_LIMIT))
        begin
            out_mv_next = OUT_LIMIT;
        end
        else if (sum < -(SMP_W+1)'(OUT_LIMIT))
        begin
            out_mv_next = -OUT_LIMIT;
        end
        else
        begin
            out_mv_next = sum[SMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_mv_reg         <= s1_reg.zero ? '0 : out_mv_next;
            active_valid_reg   <= !s1_reg.zero;
            active_channel_reg <= s1_reg.zero ? '0 : s1_reg.chan;
            skipped_reg        <= s1_reg.skip;
            offset_applied_reg <= !s1_reg.zero && s1_reg.both;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_mv         = out_mv_reg;
    assign active_valid   = active_valid_reg;
    assign active_channel = active_channel_reg;
    assign skipped        = skipped_reg;
    assign offset_applied = offset_applied_reg;

    `ASSERT_CHK(a_no_ch_zero, clk, rst_n, out_valid && !active_valid |-> out_mv == '0 && !offset_applied && active_channel == '0)
    `ASSERT_CHK(a_sat_range, clk, rst_n, out_valid |-> out_mv <= OUT_LIMIT && out_mv >= -OUT_LIMIT)
    `ASSERT_NEVER(a_stall_accept, clk, rst_n, s1_valid_reg && !s1_adv && in_ready)
    `ASSERT_CHK(a_write_marks, clk, rst_n, wr_acc |=> store_vld_reg[$past(channel)])

endmodule
